// ===== src/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, operation codes and beat types for the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

	// Queue geometry; DEPTH must be a power of two so indices wrap for free
	localparam int DEPTH  = 16;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	// Operation codes
	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	// Input beat
	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] push_value;
	} item_t;

	// Output beat
	typedef struct packed {
		logic signed [DATA_W-1:0] popped_value;
		logic                     underflow;
		logic                     overflow;
		logic [CW-1:0]            entry_count;
		logic                     is_empty;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the incoming beat
		logic exec;     // apply the operation, issue pop read
		logic peek_rd;  // capture popped data, issue front/back reads
		logic load;     // load the result register
	} ctl_cmd_t;

endpackage

`default_nettype wire

// ===== src/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read ports, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

// ===== src/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: accept a beat, execute, read back, load and hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl import deq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_stall,
	output logic      result_valid,
	input  wire logic result_stall,
	output ctl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_READ = 4'b0100,
		S_PEEK = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   result_valid_q;
	logic   out_free;

	// Result register is free when empty or being taken this cycle
	assign out_free = !result_valid_q || !result_stall;

	// Commands
	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == S_IDLE) && item_valid;
		cmd.exec    = (state_q == S_EXEC);
		cmd.peek_rd = (state_q == S_READ);
		cmd.load    = (state_q == S_PEEK) && out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) state_d = S_EXEC;
			end
			S_EXEC: state_d = S_READ;
			S_READ: state_d = S_PEEK;
			S_PEEK: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid: set on load, cleared when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

// ===== src/deq_dpath.sv =====
// ----------------------------------------------------------------------------
// deq_dpath
// Queue datapath: indices, count, slot RAM and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_dpath import deq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ctl_cmd_t cmd,
	input  wire item_t    item,
	output result_t       result
);

	item_t                    item_q;
	logic [AW-1:0]            front_q;
	logic [CW-1:0]            count_q;
	logic                     under_q;
	logic                     over_q;
	logic signed [DATA_W-1:0] popped_q;
	result_t                  result_q;

	logic                     is_pop;
	logic                     at_front;
	logic                     full;
	logic                     empty;
	logic [AW-1:0]            back_idx;
	logic [AW-1:0]            push_idx;
	logic                     ram_we;
	logic                     ram_re;
	logic [AW-1:0]            raddr_a;
	logic [DATA_W-1:0]        rdata_a;
	logic [DATA_W-1:0]        rdata_b;

	// Decode of the held operation
	assign is_pop   = (item_q.op == OP_POP_FRONT) || (item_q.op == OP_POP_BACK);
	assign at_front = (item_q.op == OP_PUSH_FRONT) || (item_q.op == OP_POP_FRONT);
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	// Slot indices, wrapping modulo DEPTH
	assign back_idx = front_q + count_q[AW-1:0] - AW'(1);
	assign push_idx = at_front ? (front_q - AW'(1)) : (front_q + count_q[AW-1:0]);

	// RAM control: pop address during exec, front/back afterwards
	assign ram_we  = cmd.exec && !is_pop && !full;
	assign ram_re  = cmd.exec || cmd.peek_rd;
	assign raddr_a = (cmd.exec && !at_front) ? back_idx : front_q;

	deq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (push_idx),
		.wdata   (item_q.push_value),
		.re      (ram_re),
		.raddr_a (raddr_a),
		.raddr_b (back_idx),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Incoming beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	// Front index and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			if (!is_pop && !full) begin
				count_q <= count_q + CW'(1);
				if (at_front) front_q <= front_q - AW'(1);
			end else if (is_pop && !empty) begin
				count_q <= count_q - CW'(1);
				if (at_front) front_q <= front_q + AW'(1);
			end
		end
	end

	// Flags and popped value
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			under_q <= is_pop && empty;
			over_q  <= !is_pop && full;
		end
		if (cmd.peek_rd) begin
			if (under_q) begin
				popped_q <= '1;
			end else if (is_pop) begin
				popped_q <= rdata_a;
			end else begin
				popped_q <= '0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			result_q.popped_value <= popped_q;
			result_q.underflow    <= under_q;
			result_q.overflow     <= over_q;
			result_q.entry_count  <= count_q;
			result_q.is_empty     <= empty;
			result_q.front_value  <= empty ? '1 : rdata_a;
			result_q.back_value   <= empty ? '1 : rdata_b;
		end
	end

	assign result = result_q;

	// Count stays within the store
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	// A pop on a non-empty queue removes exactly one entry
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && is_pop && !empty |=> count_q == $past(count_q) - CW'(1))
		else $error("pop did not decrement count");

	// A push into a full queue leaves the state alone
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && !is_pop && full |=> $stable(count_q) && $stable(front_q))
		else $error("dropped push changed queue state");

	// A result never flags both underflow and overflow
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !(result_q.underflow && result_q.overflow))
		else $error("underflow and overflow both set");

endmodule

`default_nettype wire

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values with front/back push and pop.
// ----------------------------------------------------------------------------
// Sequence: after an input beat is accepted, the sequencer walks execute, RAM read
// of the popped slot and RAM read of the front/back slots, then loads the result
// register once it is free; no new item is accepted until it is back in idle.
// A new item is accepted while the previous result is still waiting.
// Reset: arst_n clears the indices, count and handshake state at once; the
// slot RAM is not cleared and holds nothing readable until written.
`default_nettype none

module double_ended_queue import deq_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	ctl_cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	deq_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

endmodule

`default_nettype wire

// ===== tb/sv/double_ended_queue_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the double-ended queue. A driver takes operations
// from a pending list and presents them on the item channel. A monitor
// compares every result beat, field by field, with a local deque predictor.
// A short directed list covers empty pops, both push ends, extreme values and
// index wrap. Biased random runs then fill the queue to overflow and drain it
// to underflow under three sender and receiver idle mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_tb;
	import deq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 700;   // per idle phase
	localparam int DRAIN_CYCLES = 20;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// stimulus and expectation stores
	item_t   pending_items[$];
	result_t expected_beats[$];
	result_t want_beat;

	int send_idle_pct = 34;
	int recv_idle_pct = 67;
	int errors        = 0;
	int cycles        = 0;

	// predictor state: slots, head index and fill level
	logic signed [DATA_W-1:0] slots[DEPTH];
	logic [AW-1:0]            head_idx = '0;
	logic [CW-1:0]            fill     = '0;

	double_ended_queue uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one operation to the predictor and return the expected beat
	function automatic result_t deque_apply(input item_t it);
		result_t       r;
		logic [AW-1:0] tail;
		r             = '0;
		r.front_value = -1;
		r.back_value  = -1;
		case (it.op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (fill == CW'(DEPTH)) begin
					r.overflow = 1'b1;
				end else if (it.op == OP_PUSH_FRONT) begin
					head_idx        = head_idx - AW'(1);
					slots[head_idx] = it.push_value;
					fill            = fill + CW'(1);
				end else begin
					tail        = head_idx + AW'(fill);
					slots[tail] = it.push_value;
					fill        = fill + CW'(1);
				end
			end
			default: begin
				if (fill == '0) begin
					r.underflow    = 1'b1;
					r.popped_value = -1;
				end else if (it.op == OP_POP_FRONT) begin
					r.popped_value = slots[head_idx];
					head_idx       = head_idx + AW'(1);
					fill           = fill - CW'(1);
				end else begin
					tail           = head_idx + AW'(fill - CW'(1));
					r.popped_value = slots[tail];
					fill           = fill - CW'(1);
				end
			end
		endcase
		if (fill != '0) begin
			tail          = head_idx + AW'(fill - CW'(1));
			r.front_value = slots[head_idx];
			r.back_value  = slots[tail];
		end
		r.entry_count = fill;
		r.is_empty    = (fill == '0);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want)
			report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
	endtask

	task automatic queue_item(input op_t op, input logic signed [DATA_W-1:0] v);
		item_t it;
		it.op         = op;
		it.push_value = v;
		pending_items.push_back(it);
	endtask

	// Random value, leaning on the extremes now and then
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3:       return -1;
			default: return $urandom;
		endcase
	endfunction

	// Runs that favor pushes, pops, or neither, to hit full and empty often
	task automatic queue_random_runs(input int count);
		int  n;
		int  run_len;
		int  push_pct;
		bit  is_push;
		bit  at_front;
		n = 0;
		while (n < count) begin
			case ($urandom_range(2))
				0:       push_pct = 85;
				1:       push_pct = 15;
				default: push_pct = 50;
			endcase
			run_len = $urandom_range(40, 8);
			repeat (run_len) begin
				is_push  = ($urandom_range(99) < push_pct);
				at_front = 1'($urandom_range(1));
				if (is_push)
					queue_item(at_front ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
				else
					queue_item(at_front ? OP_POP_FRONT : OP_POP_BACK, pick_value());
				n++;
			end
		end
	endtask

	// Driver: predict on each accepted beat, then hold, refill or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				expected_beats.push_back(deque_apply(item));
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item       <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result beat, randomize stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want_beat = expected_beats.pop_front();
					check_field("popped_value", want_beat.popped_value, result.popped_value);
					check_field("underflow", 32'(want_beat.underflow), 32'(result.underflow));
					check_field("overflow", 32'(want_beat.overflow), 32'(result.overflow));
					check_field("entry_count", 32'(want_beat.entry_count),
						32'(result.entry_count));
					check_field("is_empty", 32'(want_beat.is_empty), 32'(result.is_empty));
					check_field("front_value", want_beat.front_value, result.front_value);
					check_field("back_value", want_beat.back_value, result.back_value);
				end
			end
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty pops, both ends, extremes, head wrap, refill after drain
		queue_item(OP_POP_FRONT, 32'sh1234_5678);
		queue_item(OP_POP_BACK, -1);
		queue_item(OP_PUSH_FRONT, 32'sh7fff_ffff);
		queue_item(OP_PUSH_BACK, 32'sh8000_0000);
		queue_item(OP_PUSH_FRONT, -1);
		queue_item(OP_PUSH_BACK, '0);
		queue_item(OP_POP_BACK, '0);
		queue_item(OP_POP_FRONT, '0);
		queue_item(OP_POP_FRONT, '0);
		queue_item(OP_POP_BACK, '0);
		queue_item(OP_POP_BACK, '0);
		queue_item(OP_PUSH_BACK, 32'sh5a5a_5a5a);
		queue_item(OP_POP_FRONT, '0);
		queue_item(OP_PUSH_FRONT, 32'sha5a5_a5a5);
		queue_item(OP_POP_BACK, '0);
		queue_item(OP_PUSH_BACK, 32'sh0000_0001);
		queue_item(OP_PUSH_FRONT, 32'sh8000_0001);
		queue_item(OP_POP_FRONT, '0);
		queue_item(OP_POP_FRONT, '0);
		queue_item(OP_POP_FRONT, '0);

		// sender idles less than receiver
		queue_random_runs(RANDOM_ITEMS);
		while (pending_items.size() != 0) @(posedge clk);

		// swap the idle mix
		send_idle_pct = 67;
		recv_idle_pct = 34;
		queue_random_runs(RANDOM_ITEMS);
		while (pending_items.size() != 0) @(posedge clk);

		// full rate both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_runs(RANDOM_ITEMS);
		while (pending_items.size() != 0 || item_valid) @(posedge clk);

		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/deq_pkg.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/deq_dpath.sv
src/double_ended_queue.sv
tb/sv/double_ended_queue_tb.sv
